[hw/rtl/midpoint_circle_rasterizer_defines.svh]
// Assertion macros used by the circle rasterizer datapath.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH

// Checked property, clocked on clk and disabled while reset is high.
`define MCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked property that also holds during reset.
`define MCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/mcr_pkg.sv]
// Package with the word types, constants and control types of the circle rasterizer.
package mcr_pkg;

  // Geometry limits.
  localparam int MAX_RADIUS  = 63;
  localparam int COORD_BITS  = 10;

  // Fixed field widths of the words.
  localparam int CENTER_BITS = 10;
  localparam int RADIUS_BITS = 6;
  localparam int OUT_BITS    = 12;
  localparam int OFS_BITS    = 7;
  localparam int DEC_BITS    = 10;

  localparam logic [CENTER_BITS-1:0] CENTER_MASK = CENTER_BITS'((1 << COORD_BITS) - 1);

  // Input word: one circle command.
  typedef struct packed {
    logic [CENTER_BITS-1:0] center_col;
    logic [CENTER_BITS-1:0] center_row;
    logic [RADIUS_BITS-1:0] radius;
  } circle_t;

  // Output word: eight mirrored points of one pass.
  typedef struct packed {
    logic signed [OUT_BITS-1:0] col_near_pos;
    logic signed [OUT_BITS-1:0] col_near_neg;
    logic signed [OUT_BITS-1:0] col_far_pos;
    logic signed [OUT_BITS-1:0] col_far_neg;
    logic signed [OUT_BITS-1:0] row_near_pos;
    logic signed [OUT_BITS-1:0] row_near_neg;
    logic signed [OUT_BITS-1:0] row_far_pos;
    logic signed [OUT_BITS-1:0] row_far_neg;
    logic                       is_cardinal;
    logic                       last_point;
  } points_t;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_loop;
    logic emit_final;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;
    logic slot_free;
  } status_t;

endpackage

[hw/rtl/mcr_ctrl.sv]
// Controller state machine of the circle rasterizer.
module mcr_ctrl
  import mcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    circle_valid,
  output logic    circle_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    circle_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        circle_stall = 1'b0;
        if (circle_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // A word is produced only when the output register can take it.
        if (status.slot_free) begin
          if (status.more) begin
            cmd.emit_loop = 1'b1;
          end else begin
            cmd.emit_final = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/mcr_datapath.sv]
// Datapath of the circle rasterizer: offsets, decision value and output register.
`include "midpoint_circle_rasterizer_defines.svh"

module mcr_datapath
  import mcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  circle_t circle,
  input  cmd_t    cmd,
  output status_t status,
  output logic    points_valid,
  input  logic    points_stall,
  output points_t points
);

  logic        [OFS_BITS-1:0]    x, y;
  logic signed [DEC_BITS-1:0]    d;
  logic        [CENTER_BITS-1:0] held_col, held_row;
  logic        [RADIUS_BITS-1:0] held_radius;

  logic        [OFS_BITS-1:0]    x_next, y_next;
  logic signed [DEC_BITS-1:0]    d_next;
  logic signed [DEC_BITS-1:0]    two_x, two_y;
  logic        [RADIUS_BITS-1:0] radius_sat;
  logic        [OFS_BITS-1:0]    ox, oy;
  logic        [OUT_BITS-1:0]    cc, cr, oxw, oyw;
  points_t                       word_next;

  // Radius saturation for the incoming command.
  assign radius_sat = (OFS_BITS'(circle.radius) > OFS_BITS'(MAX_RADIUS)) ?
                      RADIUS_BITS'(MAX_RADIUS) : circle.radius;

  // One midpoint pass.
  assign two_x = DEC_BITS'({x, 1'b0});
  assign two_y = DEC_BITS'({y, 1'b0});
  always_comb begin
    x_next = x + OFS_BITS'(1);
    if (d[DEC_BITS-1]) begin
      d_next = d + two_x + DEC_BITS'(3);
      y_next = y;
    end else begin
      d_next = d + two_x - two_y + DEC_BITS'(5);
      y_next = y - OFS_BITS'(1);
    end
  end

  assign status.more      = (x < y);
  assign status.slot_free = !points_valid || !points_stall;

  // Mirrored coordinates; the final word uses the axis offsets.
  assign ox  = cmd.emit_final ? '0 : x_next;
  assign oy  = cmd.emit_final ? OFS_BITS'(held_radius) : y_next;
  assign cc  = OUT_BITS'(held_col);
  assign cr  = OUT_BITS'(held_row);
  assign oxw = OUT_BITS'(ox);
  assign oyw = OUT_BITS'(oy);

  always_comb begin
    word_next.col_near_pos = cc + oxw;
    word_next.col_near_neg = cc - oxw;
    word_next.col_far_pos  = cc + oyw;
    word_next.col_far_neg  = cc - oyw;
    word_next.row_near_pos = cr + oxw;
    word_next.row_near_neg = cr - oxw;
    word_next.row_far_pos  = cr + oyw;
    word_next.row_far_neg  = cr - oyw;
    word_next.is_cardinal  = cmd.emit_final;
    word_next.last_point   = cmd.emit_final;
  end

  // Loop state and latched command.
  always_ff @(posedge clk) begin
    if (rst) begin
      x           <= '0;
      y           <= '0;
      d           <= '0;
      held_col    <= '0;
      held_row    <= '0;
      held_radius <= '0;
    end else if (cmd.load) begin
      x           <= '0;
      y           <= OFS_BITS'(radius_sat);
      d           <= DEC_BITS'(1) - DEC_BITS'(radius_sat);
      held_col    <= circle.center_col & CENTER_MASK;
      held_row    <= circle.center_row & CENTER_MASK;
      held_radius <= radius_sat;
    end else if (cmd.emit_loop) begin
      x <= x_next;
      y <= y_next;
      d <= d_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      points_valid <= 1'b0;
    end else if (cmd.emit_loop || cmd.emit_final) begin
      points_valid <= 1'b1;
    end else if (!points_stall) begin
      points_valid <= 1'b0;
    end
  end

  // Output register word.
  always_ff @(posedge clk) begin
    if (cmd.emit_loop || cmd.emit_final) begin
      points <= word_next;
    end
  end

  `MCR_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.load, cmd.emit_loop, cmd.emit_final}), "more than one datapath command")
  `MCR_ASSERT(a_y_bound, (y <= OFS_BITS'(held_radius)), "y offset above latched radius")
  `MCR_ASSERT(a_overshoot, (x <= y + OFS_BITS'(1)), "x offset passed y by more than one")
  `MCR_ASSERT(a_final_word, cmd.emit_final |=> (points_valid && points.last_point && points.is_cardinal), "final word not flagged")
  `MCR_ASSERT(a_no_overwrite, (points_valid && points_stall) |-> !(cmd.emit_loop || cmd.emit_final), "stalled word overwritten")

endmodule

[hw/rtl/midpoint_circle_rasterizer.sv]
// Top level of the midpoint circle rasterizer.
//
//   channel  | handshake                   | word
//   ---------+-----------------------------+----------------------------
//   circle   | circle_valid / circle_stall | circle_t: center, radius
//   points   | points_valid / points_stall | points_t: 8 points + flags
//
// A circle of radius r gives about r/1.41 loop words plus one final word,
// at most one word per cycle, set by the single midpoint pass unit.
// A circle is accepted in the idle state, after which the run state produces its words.
// The next circle is accepted in the cycle after its final word is registered.
// A stall on points holds the output register and the pass unit waits.
// Reset is synchronous and returns the block to idle with no word pending.
module midpoint_circle_rasterizer
  import mcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    circle_valid,
  output logic    circle_stall,
  input  circle_t circle,
  output logic    points_valid,
  input  logic    points_stall,
  output points_t points
);

  cmd_t    cmd;
  status_t status;

  mcr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .circle_valid (circle_valid),
    .circle_stall (circle_stall),
    .status       (status),
    .cmd          (cmd)
  );

  mcr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .circle       (circle),
    .cmd          (cmd),
    .status       (status),
    .points_valid (points_valid),
    .points_stall (points_stall),
    .points       (points)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the midpoint circle rasterizer.
module testbench;
  import mcr_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_CIRCLES = 100;
  localparam int PHASE_COUNT    = 4;
  localparam int LOOP_GUARD     = 47;
  localparam int DRAIN_CYCLES   = 60;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int DIRECTED_COUNT = 16;

  // One directed circle; a typed row carries the expected center of its only word.
  typedef struct {
    int col;
    int row;
    int rad;
    bit typed;
    int want_col;
    int want_row;
  } circle_case_t;

  logic    clk;
  logic    rst          = 1'b1;
  logic    circle_valid = 1'b0;
  logic    circle_stall;
  circle_t circle       = '0;
  logic    points_valid;
  logic    points_stall = 1'b0;
  points_t points;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int          mismatches = 0;
  points_t     expected_points[$];

  circle_case_t directed_cases [DIRECTED_COUNT] = '{
    // Zero radius: the single word holds the center on every axis point.
    '{0,    0,    0,  1'b1, 0,    0},
    '{1023, 1023, 0,  1'b1, 1023, 1023},
    '{682,  341,  0,  1'b1, 682,  341},
    // Full radius at both corners: most negative and largest coordinates.
    '{0,    0,    63, 1'b0, 0, 0},
    '{1023, 1023, 63, 1'b0, 0, 0},
    // Small radii end on the pass where x reaches or passes y.
    '{0,    1023, 1,  1'b0, 0, 0},
    '{1023, 0,    2,  1'b0, 0, 0},
    '{341,  682,  3,  1'b0, 0, 0},
    // Alternating bit patterns on all fields, then assorted circles.
    '{682,  341,  42, 1'b0, 0, 0},
    '{341,  682,  21, 1'b0, 0, 0},
    '{512,  512,  4,  1'b0, 0, 0},
    '{1,    1,    5,  1'b0, 0, 0},
    '{1022, 1022, 62, 1'b0, 0, 0},
    '{100,  900,  32, 1'b0, 0, 0},
    '{900,  100,  31, 1'b0, 0, 0},
    '{0,    0,    10, 1'b0, 0, 0}
  };

  midpoint_circle_rasterizer u_dut (
    .clk          (clk),
    .rst          (rst),
    .circle_valid (circle_valid),
    .circle_stall (circle_stall),
    .circle       (circle),
    .points_valid (points_valid),
    .points_stall (points_stall),
    .points       (points)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Builds the word of eight mirrored points for one offset pair.
  function automatic points_t mirror_points(int cc, int cr, int x, int y, bit cardinal);
    points_t w;
    w.col_near_pos = OUT_BITS'(cc + x);
    w.col_near_neg = OUT_BITS'(cc - x);
    w.col_far_pos  = OUT_BITS'(cc + y);
    w.col_far_neg  = OUT_BITS'(cc - y);
    w.row_near_pos = OUT_BITS'(cr + x);
    w.row_near_neg = OUT_BITS'(cr - x);
    w.row_far_pos  = OUT_BITS'(cr + y);
    w.row_far_neg  = OUT_BITS'(cr - y);
    w.is_cardinal  = cardinal;
    w.last_point   = cardinal;
    return w;
  endfunction

  // Runs the midpoint decision loop for one circle and queues every word it gives.
  task automatic predict_circle_points(input circle_t cmd);
    int cc;
    int cr;
    int rad;
    int x;
    int y;
    int d;
    int passes;
    cc     = int'(cmd.center_col & CENTER_MASK);
    cr     = int'(cmd.center_row & CENTER_MASK);
    rad    = int'(cmd.radius);
    passes = 0;
    if (rad > MAX_RADIUS) rad = MAX_RADIUS;
    x = 0;
    y = rad;
    d = 1 - rad;
    while (x < y && passes < LOOP_GUARD) begin
      if (d < 0) begin
        d = d + 2 * x + 3;
      end else begin
        d = d + 2 * x - 2 * y + 5;
        y = y - 1;
      end
      x = x + 1;
      expected_points.push_back(mirror_points(cc, cr, x, y, 1'b0));
      passes++;
    end
    // The closing word holds the four axis points at full radius.
    expected_points.push_back(mirror_points(cc, cr, 0, rad, 1'b1));
  endtask

  // Offers one circle word, with a random idle gap first, and waits for its acceptance.
  task automatic send_circle(input circle_t cmd);
    while ($urandom_range(99) < gap_pct) begin
      circle_valid <= 1'b0;
      circle       <= 26'($urandom);
      @(posedge clk);
    end
    circle_valid <= 1'b1;
    circle       <= cmd;
    do @(posedge clk); while (circle_stall);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // Random back pressure on the points channel.
  always @(posedge clk) begin
    points_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compares every accepted points word with the oldest expected one.
  always @(posedge clk) begin
    points_t want;
    if (!rst && points_valid && !points_stall) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        $error("points word accepted with no word expected");
      end else begin
        want = expected_points.pop_front();
        check_field("col_near_pos", want.col_near_pos, points.col_near_pos);
        check_field("col_near_neg", want.col_near_neg, points.col_near_neg);
        check_field("col_far_pos", want.col_far_pos, points.col_far_pos);
        check_field("col_far_neg", want.col_far_neg, points.col_far_neg);
        check_field("row_near_pos", want.row_near_pos, points.row_near_pos);
        check_field("row_near_neg", want.row_near_neg, points.row_near_neg);
        check_field("row_far_pos", want.row_far_pos, points.row_far_pos);
        check_field("row_far_neg", want.row_far_neg, points.row_far_neg);
        check_field("is_cardinal", want.is_cardinal, points.is_cardinal);
        check_field("last_point", want.last_point, points.last_point);
      end
    end
  end

  // Main stimulus: directed circles, then random circles over the idling phases.
  initial begin
    circle_t      cmd;
    circle_case_t tc;
    int unsigned  phase_gap   [PHASE_COUNT];
    int unsigned  phase_stall [PHASE_COUNT];
    int unsigned  pick;

    phase_gap   = '{0, 59, 0, 32};
    phase_stall = '{0, 0, 59, 32};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part runs without idling on either side.
    foreach (directed_cases[i]) begin
      tc = directed_cases[i];
      cmd.center_col = CENTER_BITS'(tc.col);
      cmd.center_row = CENTER_BITS'(tc.row);
      cmd.radius     = RADIUS_BITS'(tc.rad);
      send_circle(cmd);
      if (tc.typed) begin
        expected_points.push_back('{OUT_BITS'(tc.want_col), OUT_BITS'(tc.want_col),
                                    OUT_BITS'(tc.want_col), OUT_BITS'(tc.want_col),
                                    OUT_BITS'(tc.want_row), OUT_BITS'(tc.want_row),
                                    OUT_BITS'(tc.want_row), OUT_BITS'(tc.want_row),
                                    1'b1, 1'b1});
      end else begin
        predict_circle_points(cmd);
      end
    end

    // Random part: each phase sets its own idle and stall rates.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < RANDOM_CIRCLES / PHASE_COUNT; n++) begin
        pick = $urandom_range(7);
        cmd.center_col = (pick == 0) ? '0 : (pick == 1) ? '1 : CENTER_BITS'($urandom);
        pick = $urandom_range(7);
        cmd.center_row = (pick == 0) ? '0 : (pick == 1) ? '1 : CENTER_BITS'($urandom);
        pick = $urandom_range(7);
        cmd.radius = (pick == 0) ? '0 : (pick == 1) ? '1 : RADIUS_BITS'($urandom);
        send_circle(cmd);
        predict_circle_points(cmd);
      end
    end
    circle_valid <= 1'b0;

    // Let every expected word drain, then watch for stray words.
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
